// ----- design/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg: shared definitions for the sprite animation sequencer
// table geometry, command codes, event codes, register indexes and the
// table port request
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [7:0] CMD_MOVE  = 8'd252;
  localparam logic [7:0] CMD_TRAIT = 8'd253;
  localparam logic [7:0] CMD_STOP  = 8'd254;
  localparam logic [7:0] CMD_LOOP  = 8'd255;

  typedef logic [ADDR_W-1:0] tbl_addr_t;
  typedef tbl_addr_t addr_map_t [256];

  // byte address to table address, address modulo depth
  function automatic addr_map_t build_addr_map();
    addr_map_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = tbl_addr_t'(i % TABLE_DEPTH);
    end
    return m;
  endfunction

  localparam addr_map_t ADDR_MAP = build_addr_map();

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_MOVE = 2'd1,
    EV_STOP = 2'd2,
    EV_LOOP = 2'd3
  } event_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ENABLE = 3'd2,
    CFG_ATTACH = 3'd3,
    CFG_TRAITS = 3'd4
  } cfg_idx_t;

  // the requests to the table memory in one clock
  typedef struct packed {
    logic      rd_en;
    tbl_addr_t rd_addr;
    logic      wr_en;
    tbl_addr_t wr_addr;
    logic [7:0] wr_data;
  } tbl_req_t;

endpackage

// ----- design/spr_table.sv -----
// ----------------------------------------------------------------------------
// spr_table: animation table memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module spr_table (
  input  logic              clk,
  input  spr_pkg::tbl_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [spr_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

// ----- design/sprite_animation_sequencer.sv -----
// ----------------------------------------------------------------------------
// sprite_animation_sequencer: plays a sprite animation script
// a small microcode program walks the (frame, duration) and
// (command, parameter) pairs of the table and reports frame, offset,
// traits and script events once per input word
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  input     in_valid / in_ready    opcode, table_index, table_byte
//  output    out_valid / out_ready  frame_number, frame_offset, traits,
//                                   event_code
//  config    cfg_we                 cfg_index, cfg_data
//
//  a write word or a tick without fetch goes straight to the output step,
//  a tick with a fetch first reads frame and duration, a loop or a stop
//  without listener refetches a pair; one table read port, one byte per cycle
//  the result sits in an output register, so the next word is taken
//  while a result still waits; only the final step stalls on out_ready
//  reset (synchronous, rst high) clears cursor, frame, count, traits, step,
//  config and out_valid; result payload and table hold no reset value
//
module sprite_animation_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  table_index,
  input  logic [7:0]  table_byte,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_number,
  output logic [15:0] frame_offset,
  output logic [3:0]  traits,
  output logic [1:0]  event_code,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // program steps
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a word, start a fetch at the cursor if one is due
    ST_FRM,    // frame byte arrives, read the duration byte
    ST_TIME,   // duration arrives, decode the pair
    ST_RFRM,   // refetch after loop or stop: frame byte arrives
    ST_RTIME,  // refetch: duration arrives
    ST_OUT     // build the result word
  } step_t;

  // how the next step is chosen
  typedef enum logic [1:0] {
    BR_NEXT,    // fall to the next field
    BR_ITEM,    // branch on the incoming word
    BR_DECODE,  // multiway branch on the fetched pair
    BR_OUT      // hold until the output register is free
  } br_t;

  typedef struct packed {
    logic  ld_frame;  // frame <= table read data
    logic  ld_time;   // time_left <= table read data
    logic  rd_next;   // read the byte at cursor + 1
    br_t   br;
    step_t next;
  } ucode_t;

  // control store
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:  w = '{1'b0, 1'b0, 1'b0, BR_ITEM,   ST_IDLE};
      ST_FRM:   w = '{1'b1, 1'b0, 1'b1, BR_NEXT,   ST_TIME};
      ST_TIME:  w = '{1'b0, 1'b1, 1'b0, BR_DECODE, ST_OUT};
      ST_RFRM:  w = '{1'b1, 1'b0, 1'b1, BR_NEXT,   ST_RTIME};
      ST_RTIME: w = '{1'b0, 1'b1, 1'b0, BR_NEXT,   ST_OUT};
      ST_OUT:   w = '{1'b0, 1'b0, 1'b0, BR_OUT,    ST_IDLE};
      default:  w = '{1'b0, 1'b0, 1'b0, BR_NEXT,   ST_IDLE};
    endcase
    return w;
  endfunction

  // configuration registers
  logic [7:0]  sprite_width;
  logic [7:0]  sprite_height;
  logic        anim_enabled;
  logic        script_attached;
  logic [15:0] sprite_area;

  // sequencer state
  step_t       step;
  logic [7:0]  script_cursor;
  logic [7:0]  current_frame;
  logic [7:0]  time_left;
  logic [3:0]  trait_bits;
  logic [1:0]  ev_code;

  ucode_t            uc;
  spr_pkg::tbl_req_t tbl_req;
  logic [7:0]        rdata;
  logic [7:0]        cursor_p1;
  logic [7:0]        cursor_p2;
  logic [7:0]        cursor_m2;
  logic              fetch;
  logic              is_move;
  logic              is_trait;
  logic              is_stop;
  logic              is_loop;
  logic [23:0]       offset_prod;

  assign uc        = ucode_rom(step);
  assign in_ready  = (uc.br == BR_ITEM);
  assign cursor_p1 = script_cursor + 8'd1;
  assign cursor_p2 = script_cursor + 8'd2;
  assign cursor_m2 = script_cursor - 8'd2;
  assign fetch     = (time_left == 8'd0) && anim_enabled;

  // command match, first one wins
  assign is_move  = (current_frame == spr_pkg::CMD_MOVE);
  assign is_trait = !is_move && (current_frame == spr_pkg::CMD_TRAIT);
  assign is_stop  = !is_move && !is_trait && (current_frame == spr_pkg::CMD_STOP);
  assign is_loop  = !is_move && !is_trait && !is_stop &&
                    (current_frame == spr_pkg::CMD_LOOP);

  assign offset_prod = 24'(current_frame) * 24'(sprite_area);

  // table port requests
  always_comb begin
    tbl_req         = '0;
    tbl_req.wr_addr = table_index[spr_pkg::ADDR_W-1:0];
    tbl_req.wr_data = table_byte;
    case (uc.br)
      BR_ITEM: begin
        if (in_valid) begin
          if (opcode == spr_pkg::OP_WRITE) begin
            // writes beyond the depth are dropped
            tbl_req.wr_en = ({1'b0, table_index} < 9'(spr_pkg::TABLE_DEPTH));
          end else begin
            tbl_req.rd_en   = fetch;
            tbl_req.rd_addr = spr_pkg::ADDR_MAP[script_cursor];
          end
        end
      end
      BR_DECODE: begin
        if (is_stop && !script_attached) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = spr_pkg::ADDR_MAP[cursor_m2];
        end else if (is_loop) begin
          // loop target is the duration byte just read
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = spr_pkg::ADDR_MAP[rdata];
        end
      end
      default: begin
        if (uc.rd_next) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = spr_pkg::ADDR_MAP[cursor_p1];
        end
      end
    endcase
  end

  spr_table u_table (
    .clk   (clk),
    .req   (tbl_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= ST_IDLE;
      sprite_width    <= '0;
      sprite_height   <= '0;
      anim_enabled    <= 1'b0;
      script_attached <= 1'b0;
      sprite_area     <= '0;
      script_cursor   <= '0;
      current_frame   <= '0;
      time_left       <= '0;
      trait_bits      <= '0;
      ev_code         <= spr_pkg::EV_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spr_pkg::CFG_WIDTH:  sprite_width    <= cfg_data;
          spr_pkg::CFG_HEIGHT: sprite_height   <= cfg_data;
          spr_pkg::CFG_ENABLE: anim_enabled    <= cfg_data[0];
          spr_pkg::CFG_ATTACH: script_attached <= cfg_data[0];
          spr_pkg::CFG_TRAITS: trait_bits      <= cfg_data[3:0];
          default: ;
        endcase
      end

      // pixel count per frame, registered from width and height
      sprite_area <= 16'(sprite_width) * 16'(sprite_height);

      // the output step reloads the register itself when it is taken
      if (out_valid && out_ready && (uc.br != BR_OUT)) begin
        out_valid <= 1'b0;
      end

      if (uc.ld_frame) begin
        current_frame <= rdata;
      end
      if (uc.ld_time) begin
        time_left <= rdata;
      end

      case (uc.br)
        BR_NEXT: begin
          step <= uc.next;
        end
        BR_ITEM: begin
          if (in_valid) begin
            ev_code <= spr_pkg::EV_NONE;
            if (opcode == spr_pkg::OP_TICK) begin
              time_left <= time_left - 8'd1;
              step      <= fetch ? ST_FRM : ST_OUT;
            end else begin
              step <= ST_OUT;
            end
          end
        end
        BR_DECODE: begin
          if (is_move) begin
            ev_code       <= script_attached ? spr_pkg::EV_MOVE : spr_pkg::EV_NONE;
            script_cursor <= cursor_p2;
            step          <= ST_OUT;
          end else if (is_trait) begin
            trait_bits    <= rdata[3:0];
            script_cursor <= cursor_p2;
            step          <= ST_OUT;
          end else if (is_stop) begin
            if (script_attached) begin
              // hold the cursor, the stop pair comes back next time
              ev_code <= spr_pkg::EV_STOP;
              step    <= ST_OUT;
            end else begin
              // back up one pair and show it undecoded
              script_cursor <= cursor_m2;
              step          <= ST_RFRM;
            end
          end else if (is_loop) begin
            ev_code       <= script_attached ? spr_pkg::EV_LOOP : spr_pkg::EV_NONE;
            script_cursor <= rdata;
            step          <= ST_RFRM;
          end else begin
            script_cursor <= cursor_p2;
            step          <= ST_OUT;
          end
        end
        BR_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            frame_number <= current_frame;
            frame_offset <= offset_prod[18:3];
            traits       <= trait_bits;
            event_code   <= ev_code;
            step         <= uc.next;
          end
        end
        default: begin
          step <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
